// File: hdl/rfid_pkg.sv
package rfid_pkg;

    localparam logic [7:0] START_BYTE = 8'h02;
    localparam logic [7:0] END_BYTE   = 8'h03;

    localparam int POS_W = 4;
    localparam logic [POS_W-1:0] POS_HUNT  = 4'd0;
    localparam logic [POS_W-1:0] POS_TAG0  = 4'd3;
    localparam logic [POS_W-1:0] POS_DATA6 = 4'd6;
    localparam logic [POS_W-1:0] POS_CHECK = 4'd7;
    localparam logic [POS_W-1:0] POS_END   = 4'd8;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MENU    = 1'b1;

    localparam logic [15:0] TIMEOUT_RESET = 16'd100;
    localparam logic [15:0] TICK_MAX      = 16'hFFFF;

    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    typedef struct packed {
        logic [31:0] tag_value;
        logic        to_menu;
    } result_t;

    typedef struct packed {
        logic        full;
    } buf_ctrl_t;

endpackage

// File: hdl/rfid_if.sv
interface rfid_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] rx_byte;

    modport source (output valid, output mode, output rx_byte, input ready);
    modport sink (input valid, input mode, input rx_byte, output ready);
endinterface

interface rfid_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] tag_value;
    logic        to_menu;

    modport source (output valid, output tag_value, output to_menu, input ready);
    modport sink (input valid, input tag_value, input to_menu, output ready);
endinterface

// File: hdl/rfid_frame_deframer.sv
// rfid frame deframer
// in_ch takes one item per request: mode 0 carries a received serial byte in
// rx_byte, mode 1 marks one timer tick. the block hunts for a 0x02 start
// byte, collects six data bytes, an xor checksum and a 0x03 end byte, and
// drops the frame if the tick count since the start byte reaches
// timeout_ticks before the end byte.
// out_ch delivers one request per good frame: tag_value is data bytes 3..6
// (byte 3 in the low bits), to_menu is menu_select at the end byte.
// config: cfg_we with cfg_index 0 writes timeout_ticks, index 1 menu_select;
// write only while the block is idle.
// throughput: one item per cycle, unless a good frame's end byte waits on a full result buffer.
// an accepted end byte passes the input register, then the result buffer,
// before out_ch can take its tag.
// reset clears the frame state and both stages; timeout_ticks returns to 100
// and menu_select to 0.
// when out_ch stalls, the two-entry result buffer fills and then in_ch holds
// ready low only while an end byte that completes a good frame waits.
module rfid_frame_deframer
    import rfid_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    rfid_in_if.sink               in_ch,
    rfid_out_if.source            out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic        s1_valid_reg, s1_valid_next;
    logic        s1_mode_reg;
    logic [7:0]  s1_byte_reg;
    logic [15:0] timeout_reg;
    logic        menu_reg;
    logic        res_valid;
    result_t     res;
    logic        s1_fire;
    logic        in_fire;
    buf_ctrl_t   buf_ctrl;

    // an item that yields a result waits only when the buffer is full
    assign s1_fire      = s1_valid_reg && !(res_valid && buf_ctrl.full);
    assign in_ch.ready  = !s1_valid_reg || s1_fire;
    assign in_fire      = in_ch.valid && in_ch.ready;
    assign s1_valid_next = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_mode_reg <= in_ch.mode;
            s1_byte_reg <= in_ch.rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            timeout_reg  <= TIMEOUT_RESET;
            menu_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_TIMEOUT: timeout_reg <= cfg_wdata;
                    CFG_MENU:    menu_reg    <= cfg_wdata[0];
                    default:     ;
                endcase
            end
        end
    end

    rfid_frame_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (s1_fire),
        .mode          (s1_mode_reg),
        .rx_byte       (s1_byte_reg),
        .timeout_ticks (timeout_reg),
        .menu_select   (menu_reg),
        .res_valid     (res_valid),
        .res           (res)
    );

    rfid_out_buf u_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s1_fire && res_valid),
        .push_data (res),
        .ctrl      (buf_ctrl),
        .out_ch    (out_ch)
    );

endmodule

// File: hdl/rfid_frame_core.sv
module rfid_frame_core
    import rfid_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  logic        mode,
    input  logic [7:0]  rx_byte,
    input  logic [15:0] timeout_ticks,
    input  logic        menu_select,
    output logic        res_valid,
    output result_t     res
);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       xor_reg, xor_next;
    logic [31:0]      tag_reg, tag_next;
    logic             chk_reg, chk_next;
    logic [15:0]      elapsed_reg, elapsed_next;
    logic [15:0]      elapsed_inc;
    logic             is_tick;
    logic             hunting;

    assign is_tick     = (mode == MODE_TICK);
    assign hunting     = (pos_reg == POS_HUNT) || (pos_reg > POS_END);
    assign elapsed_inc = (elapsed_reg == TICK_MAX) ? elapsed_reg : elapsed_reg + 16'd1;

    // a frame is good only on the end byte with the checksum already matched
    assign res_valid     = !is_tick && (pos_reg == POS_END) && (rx_byte == END_BYTE) && chk_reg;
    assign res.tag_value = tag_reg;
    assign res.to_menu   = menu_select;

    always_comb
    begin
        pos_next     = pos_reg;
        xor_next     = xor_reg;
        tag_next     = tag_reg;
        chk_next     = chk_reg;
        elapsed_next = elapsed_reg;
        if (fire)
        begin
            if (hunting)
            begin
                pos_next = POS_HUNT;
                if (!is_tick && rx_byte == START_BYTE)
                begin
                    xor_next     = 8'd0;
                    tag_next     = 32'd0;
                    chk_next     = 1'b0;
                    elapsed_next = 16'd0;
                    pos_next     = 4'd1;
                end
            end
            else if (is_tick)
            begin
                elapsed_next = elapsed_inc;
                if (elapsed_inc >= timeout_ticks)
                begin
                    pos_next     = POS_HUNT;
                    xor_next     = 8'd0;
                    tag_next     = 32'd0;
                    chk_next     = 1'b0;
                    elapsed_next = 16'd0;
                end
            end
            else if (pos_reg <= POS_DATA6)
            begin
                xor_next = xor_reg ^ rx_byte;
                if (pos_reg >= POS_TAG0)
                begin
                    tag_next = {rx_byte, tag_reg[31:8]};
                end
                pos_next = pos_reg + 4'd1;
            end
            else if (pos_reg == POS_CHECK)
            begin
                chk_next = (rx_byte == xor_reg);
                pos_next = POS_END;
            end
            else
            begin
                pos_next     = POS_HUNT;
                xor_next     = 8'd0;
                tag_next     = 32'd0;
                chk_next     = 1'b0;
                elapsed_next = 16'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= POS_HUNT;
            xor_reg     <= 8'd0;
            tag_reg     <= 32'd0;
            chk_reg     <= 1'b0;
            elapsed_reg <= 16'd0;
        end
        else
        begin
            pos_reg     <= pos_next;
            xor_reg     <= xor_next;
            tag_reg     <= tag_next;
            chk_reg     <= chk_next;
            elapsed_reg <= elapsed_next;
        end
    end

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_END)
        else $error("frame position out of range");

    a_start_sync: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && pos_reg == POS_HUNT && !is_tick && rx_byte == START_BYTE)
        |=> (pos_reg == 4'd1 && elapsed_reg == 16'd0 && xor_reg == 8'd0))
        else $error("start byte did not open a frame");

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg == POS_HUNT) |-> (elapsed_reg == 16'd0 && xor_reg == 8'd0))
        else $error("stale frame state while hunting");

endmodule

// File: hdl/rfid_out_buf.sv
module rfid_out_buf
    import rfid_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  result_t   push_data,
    output buf_ctrl_t ctrl,
    rfid_out_if.source out_ch
);

    result_t    mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;
    result_t    head;

    assign pop       = (count_reg != 2'd0) && out_ch.ready;
    assign head      = mem[rd_ptr_reg];
    assign ctrl.full = (count_reg == 2'd2);

    assign out_ch.valid     = (count_reg != 2'd0);
    assign out_ch.tag_value = head.tag_value;
    assign out_ch.to_menu   = head.to_menu;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'd2)
        else $error("result buffer count out of range");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && ctrl.full))
        else $error("push into full result buffer");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("result buffer pointers disagree with count");

endmodule
